// ===== design/ebagg_pkg.sv =====
`timescale 1ns / 1ps

package ebagg_pkg;

    // Default sizes of the stores
    localparam int DEF_MAX_TERMS    = 1024;
    localparam int DEF_MAX_OUTPUTS  = 64;
    localparam int DEF_TERM_BITS    = 256;

    // Fixed port widths
    localparam int PORT_BITS        = 256;
    localparam int ONES_W           = 32;

    // Widest accepted signed term, in bytes
    localparam int SIGNED_MAX_BYTES = 16;

    typedef enum logic [1:0] {
        FUNC_AGG     = 2'd0,
        FUNC_RD_TERM = 2'd1,
        FUNC_RD_OUT  = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_WIDTH = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

    // Control for one beat between the prepare and accumulate stages
    typedef struct packed {
        logic    vld;
        func_t   func;
        logic    neg;
        status_t status;
        logic    upd;
    } ctl_t;

endpackage

// ===== design/ebagg_table.sv =====
`timescale 1ns / 1ps

// Single-port-write, single-port-read store with registered read data.
// A write and a read of the same entry at one edge return the new data.
module ebagg_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 256
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, write-first on a clash
    always_ff @(posedge clk)
    begin
        if (we && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ebagg_prep.sv =====
`timescale 1ns / 1ps

// Input register, then term preparation: width mask, sign handling,
// status and table addresses. Issues the table reads.
module ebagg_prep import ebagg_pkg::*; #(
    parameter int MAX_TERMS   = DEF_MAX_TERMS,
    parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
    parameter int TERM_BITS   = DEF_TERM_BITS,
    parameter int TA_W        = 10,
    parameter int OA_W        = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           func,
    input  logic [63:0]          term_w0,
    input  logic [63:0]          term_w1,
    input  logic [63:0]          term_w2,
    input  logic [63:0]          term_w3,
    input  logic [5:0]           term_bytes,
    input  logic                 term_sgn,
    input  logic [9:0]           term_pos,
    input  logic [5:0]           base_output,
    output logic [TA_W-1:0]      term_raddr,
    output logic [OA_W-1:0]      out_raddr,
    output ctl_t                 s1_ctl,
    output logic [TERM_BITS-1:0] s1_term,
    output logic [TA_W-1:0]      s1_taddr,
    output logic [OA_W-1:0]      s1_oaddr
);

    localparam int MAXB = TERM_BITS / 8;
    localparam int NB_W = $clog2(TERM_BITS + 1);

    // Input register
    logic                 in_vld_reg;
    func_t                func_reg;
    logic [PORT_BITS-1:0] term_reg;
    logic [5:0]           bytes_reg;
    logic                 sgn_reg;
    logic [9:0]           ti_reg;
    logic [5:0]           bo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func_t'(func);
            term_reg  <= {term_w3, term_w2, term_w1, term_w0};
            bytes_reg <= term_bytes;
            sgn_reg   <= term_sgn;
            ti_reg    <= term_pos;
            bo_reg    <= base_output;
        end
    end

    // Term preparation
    logic                 bad_w;
    logic [5:0]           bytes_eff;
    logic [NB_W-1:0]      nb;
    logic [TERM_BITS-1:0] mask;
    logic [TERM_BITS-1:0] tm;
    logic [TERM_BITS-1:0] top_bit;
    logic [TERM_BITS-1:0] tneg;
    logic [TERM_BITS-1:0] t;
    logic                 sign;
    logic                 most_neg;
    logic                 neg_raw;
    logic [6:0]           oi_full;
    logic                 ti_bad;
    logic                 bo_bad;
    logic                 range_bad;
    ctl_t                 ctl;

    always_comb
    begin
        bad_w = sgn_reg && !(bytes_reg == 6'd1 || bytes_reg == 6'd2 || bytes_reg == 6'd4 ||
                             bytes_reg == 6'd8 || bytes_reg == 6'(SIGNED_MAX_BYTES));
        // unsigned terms wider than the store are cut
        if (!sgn_reg && (32'(bytes_reg) > MAXB))
        begin
            bytes_eff = 6'(MAXB);
        end
        else
        begin
            bytes_eff = bytes_reg;
        end
        nb = NB_W'({bytes_eff, 3'b000});
        for (int i = 0; i < TERM_BITS; i++)
        begin
            mask[i] = (NB_W'(i) < nb);
        end
        tm       = term_reg[TERM_BITS-1:0] & mask;
        top_bit  = mask & ~(mask >> 1);
        sign     = sgn_reg && !bad_w && (|(tm & top_bit));
        // most negative value keeps its bits and counts as non-negative
        most_neg = (tm == top_bit);
        neg_raw  = sign && !most_neg;
        tneg     = (~tm + TERM_BITS'(1)) & mask;
        t        = neg_raw ? tneg : tm;
    end

    // Status, routing and update decision
    always_comb
    begin
        oi_full   = {1'b0, bo_reg} + 7'(neg_raw);
        ti_bad    = (32'(ti_reg) >= MAX_TERMS);
        bo_bad    = (32'(bo_reg) >= MAX_OUTPUTS);
        range_bad = ti_bad || (32'(oi_full) >= MAX_OUTPUTS);

        ctl.vld    = in_vld_reg;
        ctl.func   = func_reg;
        ctl.neg    = 1'b0;
        ctl.status = ST_OK;
        ctl.upd    = 1'b0;
        unique case (func_reg)
            FUNC_AGG:
            begin
                if (bad_w)
                begin
                    ctl.status = ST_BAD_WIDTH;
                end
                else if (range_bad)
                begin
                    ctl.status = ST_RANGE;
                end
                else
                begin
                    ctl.neg = neg_raw;
                    ctl.upd = 1'b1;
                end
            end
            FUNC_RD_TERM:
            begin
                ctl.status = ti_bad ? ST_RANGE : ST_OK;
            end
            FUNC_RD_OUT:
            begin
                ctl.status = bo_bad ? ST_RANGE : ST_OK;
            end
            FUNC_CLEAR:
            begin
                ctl.status = ST_OK;
            end
            default:
            begin
                ctl.status = ST_OK;
            end
        endcase
    end

    // Table read addresses
    assign term_raddr = TA_W'(ti_reg);
    assign out_raddr  = (func_reg == FUNC_RD_OUT) ? OA_W'({1'b0, bo_reg}) : OA_W'(oi_full);

    // Stage register
    ctl_t                 s1_ctl_reg;
    logic [TERM_BITS-1:0] s1_term_reg;
    logic [TA_W-1:0]      s1_taddr_reg;
    logic [OA_W-1:0]      s1_oaddr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_term_reg  <= t;
        s1_taddr_reg <= term_raddr;
        s1_oaddr_reg <= out_raddr;
    end

    assign s1_ctl   = s1_ctl_reg;
    assign s1_term  = s1_term_reg;
    assign s1_taddr = s1_taddr_reg;
    assign s1_oaddr = s1_oaddr_reg;

endmodule

// ===== design/ebagg_accum.sv =====
`timescale 1ns / 1ps

// Read-modify-write of both tables, running maximum, saturating set-bit
// total and the result register.
module ebagg_accum import ebagg_pkg::*; #(
    parameter int TERM_BITS = DEF_TERM_BITS,
    parameter int TA_W      = 10,
    parameter int OA_W      = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_t                 s1_ctl,
    input  logic [TERM_BITS-1:0] s1_term,
    input  logic [TA_W-1:0]      s1_taddr,
    input  logic [OA_W-1:0]      s1_oaddr,
    input  logic [TERM_BITS-1:0] rd_term,
    input  logic [TERM_BITS-1:0] rd_out,
    output logic                 term_we,
    output logic [TA_W-1:0]      term_waddr,
    output logic [TERM_BITS-1:0] term_wdata,
    output logic                 out_we,
    output logic [OA_W-1:0]      out_waddr,
    output logic [TERM_BITS-1:0] out_wdata,
    output logic                 res_vld,
    output logic [TERM_BITS-1:0] res_data,
    output logic [ONES_W-1:0]    res_ones,
    output logic                 res_neg,
    output status_t              res_status
);

    localparam int POP_W = $clog2(TERM_BITS + 1);

    logic [TERM_BITS-1:0] max_reg;
    logic [TERM_BITS-1:0] max_next;
    logic [ONES_W-1:0]    ones_reg;
    logic [ONES_W-1:0]    ones_next;
    logic [POP_W-1:0]     pop;
    logic [ONES_W:0]      ones_sum;
    logic                 do_upd;
    logic                 do_clr;
    logic [TERM_BITS-1:0] data_next;

    assign do_upd = s1_ctl.vld && s1_ctl.upd;
    assign do_clr = s1_ctl.vld && (s1_ctl.func == FUNC_CLEAR);

    // Table write-back
    assign term_we    = do_upd;
    assign term_waddr = s1_taddr;
    assign term_wdata = rd_term | s1_term;
    assign out_we     = do_upd;
    assign out_waddr  = s1_oaddr;
    assign out_wdata  = rd_out | s1_term;

    // Set-bit count of the term
    always_comb
    begin
        pop = '0;
        for (int i = 0; i < TERM_BITS; i++)
        begin
            pop = pop + POP_W'(s1_term[i]);
        end
    end

    // Running state update
    always_comb
    begin
        ones_sum  = {1'b0, ones_reg} + (ONES_W + 1)'(pop);
        max_next  = max_reg;
        ones_next = ones_reg;
        if (do_clr)
        begin
            max_next  = '0;
            ones_next = '0;
        end
        else if (do_upd)
        begin
            if (s1_term > max_reg)
            begin
                max_next = s1_term;
            end
            ones_next = ones_sum[ONES_W] ? '1 : ones_sum[ONES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= '0;
            ones_reg <= '0;
        end
        else
        begin
            max_reg  <= max_next;
            ones_reg <= ones_next;
        end
    end

    // Result data select
    always_comb
    begin
        unique case (s1_ctl.func)
            FUNC_AGG:     data_next = max_next;
            FUNC_RD_TERM: data_next = (s1_ctl.status == ST_OK) ? rd_term : '0;
            FUNC_RD_OUT:  data_next = (s1_ctl.status == ST_OK) ? rd_out : '0;
            FUNC_CLEAR:   data_next = '0;
            default:      data_next = '0;
        endcase
    end

    // Result register
    logic                 res_vld_reg;
    logic [TERM_BITS-1:0] res_data_reg;
    logic [ONES_W-1:0]    res_ones_reg;
    logic                 res_neg_reg;
    status_t              res_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= s1_ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg   <= data_next;
        res_ones_reg   <= ones_next;
        res_neg_reg    <= s1_ctl.neg;
        res_status_reg <= s1_ctl.status;
    end

    assign res_vld    = res_vld_reg;
    assign res_data   = res_data_reg;
    assign res_ones   = res_ones_reg;
    assign res_neg    = res_neg_reg;
    assign res_status = res_status_reg;

endmodule

// ===== design/exponent_bit_aggregator.sv =====
// An accepted item reaches done through the input, stage and result registers.
// Throughput: one item per cycle while busy is low; the table read-modify-write
// is forwarded. Reset and clear items run a clearing pass of max(MAX_TERMS,
// MAX_OUTPUTS) entries on both tables, one entry a cycle, busy high throughout;
// a clear item holds busy as it passes the input and stage registers first.
// Results are shown for one cycle on done; the receiver cannot stall them.
`timescale 1ns / 1ps

module exponent_bit_aggregator import ebagg_pkg::*; #(
    parameter int MAX_TERMS   = DEF_MAX_TERMS,
    parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
    parameter int TERM_BITS   = DEF_TERM_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [63:0] term_w0,
    input  logic [63:0] term_w1,
    input  logic [63:0] term_w2,
    input  logic [63:0] term_w3,
    input  logic [5:0]  term_bytes,
    input  logic        term_sgn,
    input  logic [9:0]  term_pos,
    input  logic [5:0]  base_output,
    output logic        done,
    output logic [63:0] data_w0,
    output logic [63:0] data_w1,
    output logic [63:0] data_w2,
    output logic [63:0] data_w3,
    output logic [31:0] total_ones,
    output logic        went_negative,
    output logic [1:0]  status
);

    localparam int TA_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int OA_W     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int SW_DEPTH = (MAX_TERMS > MAX_OUTPUTS) ? MAX_TERMS : MAX_OUTPUTS;
    localparam int SWA_W    = (SW_DEPTH > 1) ? $clog2(SW_DEPTH) : 1;

    logic                 accept;
    logic [TA_W-1:0]      term_raddr;
    logic [OA_W-1:0]      out_raddr;
    ctl_t                 s1_ctl;
    logic [TERM_BITS-1:0] s1_term;
    logic [TA_W-1:0]      s1_taddr;
    logic [OA_W-1:0]      s1_oaddr;
    logic [TERM_BITS-1:0] rd_term;
    logic [TERM_BITS-1:0] rd_out;
    logic                 acc_term_we;
    logic [TA_W-1:0]      acc_term_waddr;
    logic [TERM_BITS-1:0] acc_term_wdata;
    logic                 acc_out_we;
    logic [OA_W-1:0]      acc_out_waddr;
    logic [TERM_BITS-1:0] acc_out_wdata;
    logic                 res_vld;
    logic [TERM_BITS-1:0] res_data;
    logic [ONES_W-1:0]    res_ones;
    logic                 res_neg;
    status_t              res_status;

    // Clearing pass control
    logic             sweep_reg;
    logic             sweep_next;
    logic [SWA_W-1:0] sweep_idx_reg;
    logic [SWA_W-1:0] sweep_idx_next;
    logic             clr_pend_reg;
    logic             clr_pend_next;
    logic             start_clear;
    logic             sweep_last;

    assign busy        = sweep_reg || clr_pend_reg;
    assign accept      = start && !busy;
    assign start_clear = s1_ctl.vld && (s1_ctl.func == FUNC_CLEAR);
    assign sweep_last  = (sweep_idx_reg == SWA_W'(SW_DEPTH - 1));

    always_comb
    begin
        sweep_next     = sweep_reg;
        sweep_idx_next = sweep_idx_reg;
        clr_pend_next  = clr_pend_reg;
        if (accept && (func_t'(func) == FUNC_CLEAR))
        begin
            clr_pend_next = 1'b1;
        end
        if (start_clear)
        begin
            clr_pend_next  = 1'b0;
            sweep_next     = 1'b1;
            sweep_idx_next = '0;
        end
        else if (sweep_reg)
        begin
            if (sweep_last)
            begin
                sweep_next = 1'b0;
            end
            else
            begin
                sweep_idx_next = sweep_idx_reg + SWA_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
            clr_pend_reg  <= 1'b0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            sweep_idx_reg <= sweep_idx_next;
            clr_pend_reg  <= clr_pend_next;
        end
    end

    // Table write muxing: clearing pass or item write-back
    logic                 term_we;
    logic [TA_W-1:0]      term_waddr;
    logic [TERM_BITS-1:0] term_wdata;
    logic                 out_we;
    logic [OA_W-1:0]      out_waddr;
    logic [TERM_BITS-1:0] out_wdata;

    always_comb
    begin
        if (sweep_reg)
        begin
            term_we    = (32'(sweep_idx_reg) < MAX_TERMS);
            term_waddr = TA_W'(sweep_idx_reg);
            term_wdata = '0;
            out_we     = (32'(sweep_idx_reg) < MAX_OUTPUTS);
            out_waddr  = OA_W'(sweep_idx_reg);
            out_wdata  = '0;
        end
        else
        begin
            term_we    = acc_term_we;
            term_waddr = acc_term_waddr;
            term_wdata = acc_term_wdata;
            out_we     = acc_out_we;
            out_waddr  = acc_out_waddr;
            out_wdata  = acc_out_wdata;
        end
    end

    ebagg_prep #(
        .MAX_TERMS   (MAX_TERMS),
        .MAX_OUTPUTS (MAX_OUTPUTS),
        .TERM_BITS   (TERM_BITS),
        .TA_W        (TA_W),
        .OA_W        (OA_W)
    ) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (func),
        .term_w0     (term_w0),
        .term_w1     (term_w1),
        .term_w2     (term_w2),
        .term_w3     (term_w3),
        .term_bytes  (term_bytes),
        .term_sgn    (term_sgn),
        .term_pos    (term_pos),
        .base_output (base_output),
        .term_raddr  (term_raddr),
        .out_raddr   (out_raddr),
        .s1_ctl      (s1_ctl),
        .s1_term     (s1_term),
        .s1_taddr    (s1_taddr),
        .s1_oaddr    (s1_oaddr)
    );

    ebagg_table #(
        .DEPTH (MAX_TERMS),
        .AW    (TA_W),
        .DW    (TERM_BITS)
    ) u_term_table (
        .clk     (clk),
        .rd_addr (term_raddr),
        .rd_data (rd_term),
        .we      (term_we),
        .wr_addr (term_waddr),
        .wr_data (term_wdata)
    );

    ebagg_table #(
        .DEPTH (MAX_OUTPUTS),
        .AW    (OA_W),
        .DW    (TERM_BITS)
    ) u_out_table (
        .clk     (clk),
        .rd_addr (out_raddr),
        .rd_data (rd_out),
        .we      (out_we),
        .wr_addr (out_waddr),
        .wr_data (out_wdata)
    );

    ebagg_accum #(
        .TERM_BITS (TERM_BITS),
        .TA_W      (TA_W),
        .OA_W      (OA_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_ctl     (s1_ctl),
        .s1_term    (s1_term),
        .s1_taddr   (s1_taddr),
        .s1_oaddr   (s1_oaddr),
        .rd_term    (rd_term),
        .rd_out     (rd_out),
        .term_we    (acc_term_we),
        .term_waddr (acc_term_waddr),
        .term_wdata (acc_term_wdata),
        .out_we     (acc_out_we),
        .out_waddr  (acc_out_waddr),
        .out_wdata  (acc_out_wdata),
        .res_vld    (res_vld),
        .res_data   (res_data),
        .res_ones   (res_ones),
        .res_neg    (res_neg),
        .res_status (res_status)
    );

    // Result ports
    logic [PORT_BITS-1:0] data_ext;

    assign data_ext      = PORT_BITS'(res_data);
    assign done          = res_vld;
    assign data_w0       = data_ext[63:0];
    assign data_w1       = data_ext[127:64];
    assign data_w2       = data_ext[191:128];
    assign data_w3       = data_ext[255:192];
    assign total_ones    = res_ones;
    assign went_negative = res_neg;
    assign status        = res_status;

    // Checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("accepted beat gave no result three cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without a matching accepted beat");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func_t'(func) == FUNC_CLEAR)) |=> busy)
        else $error("clear beat did not block further input");

    a_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(sweep_reg && (acc_term_we || acc_out_we)))
        else $error("item write-back during clearing pass");

    a_fail_no_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (res_status != ST_OK)) |-> !went_negative)
        else $error("failed beat flagged as negative");

endmodule

// ===== test/exponent_bit_aggregator_tb.sv =====
`timescale 1ns / 1ps

module exponent_bit_aggregator_tb import ebagg_pkg::*;;

    // One command beat, then the answer it should produce
    typedef struct {
        func_t        op;
        logic [255:0] term;
        logic [5:0]   nbytes;
        logic         sgn;
        logic [9:0]   tidx;
        logic [5:0]   bout;
    } agg_item_t;

    typedef struct {
        logic [255:0] data;
        logic [31:0]  ones;
        logic         neg;
        status_t      st;
    } agg_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [63:0] term_w0;
    logic [63:0] term_w1;
    logic [63:0] term_w2;
    logic [63:0] term_w3;
    logic [5:0]  term_bytes;
    logic        term_sgn;
    logic [9:0]  term_pos;
    logic [5:0]  base_output;
    logic        done;
    logic [63:0] data_w0;
    logic [63:0] data_w1;
    logic [63:0] data_w2;
    logic [63:0] data_w3;
    logic [31:0] total_ones;
    logic        went_negative;
    logic [1:0]  status;

    // Predicted contents of the block's stores
    logic [255:0] term_tbl [DEF_MAX_TERMS];
    logic [255:0] out_tbl [DEF_MAX_OUTPUTS];
    logic [255:0] max_term;
    logic [31:0]  ones_sum;

    agg_result_t agg_results_due [$];
    int          err_count;
    bit          back_to_back;

    exponent_bit_aggregator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .term_w0       (term_w0),
        .term_w1       (term_w1),
        .term_w2       (term_w2),
        .term_w3       (term_w3),
        .term_bytes    (term_bytes),
        .term_sgn      (term_sgn),
        .term_pos      (term_pos),
        .base_output   (base_output),
        .done          (done),
        .data_w0       (data_w0),
        .data_w1       (data_w1),
        .data_w2       (data_w2),
        .data_w3       (data_w3),
        .total_ones    (total_ones),
        .went_negative (went_negative),
        .status        (status)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void clear_stores();
        for (int i = 0; i < DEF_MAX_TERMS; i++)
            term_tbl[i] = '0;
        for (int i = 0; i < DEF_MAX_OUTPUTS; i++)
            out_tbl[i] = '0;
        max_term = '0;
        ones_sum = '0;
    endfunction

    // Applies one accepted beat to the predicted stores and returns its answer
    function automatic agg_result_t compute_agg_result(input agg_item_t it);
        agg_result_t  r;
        logic [255:0] mask;
        logic [255:0] t;
        logic [32:0]  sum;
        logic [6:0]   slot;
        int unsigned  nbytes;
        int unsigned  nb;
        logic         neg;
        r.data = max_term;
        r.neg  = 1'b0;
        r.st   = ST_OK;
        case (it.op)
            FUNC_AGG:
            begin
                nbytes = it.nbytes;
                if (it.sgn && nbytes != 1 && nbytes != 2 && nbytes != 4 && nbytes != 8 &&
                    nbytes != SIGNED_MAX_BYTES)
                    r.st = ST_BAD_WIDTH;
                else
                begin
                    if (!it.sgn && nbytes > DEF_TERM_BITS / 8)
                        nbytes = DEF_TERM_BITS / 8;
                    nb   = nbytes * 8;
                    mask = (nb >= 256) ? '1 : ((256'd1 << nb) - 256'd1);
                    t    = it.term & mask;
                    neg  = 1'b0;
                    // most negative value keeps its bits and counts as non-negative
                    if (it.sgn && t[nb - 1] && t != (256'd1 << (nb - 1)))
                    begin
                        t   = (~t + 256'd1) & mask;
                        neg = 1'b1;
                    end
                    slot = {1'b0, it.bout} + 7'(neg);
                    if (it.tidx >= DEF_MAX_TERMS || slot >= DEF_MAX_OUTPUTS)
                        r.st = ST_RANGE;
                    else
                    begin
                        term_tbl[it.tidx] |= t;
                        out_tbl[slot]     |= t;
                        if (t > max_term)
                            max_term = t;
                        sum      = {1'b0, ones_sum} + 33'($countones(t));
                        ones_sum = sum[32] ? '1 : sum[31:0];
                        r.neg    = neg;
                    end
                    r.data = max_term;
                end
            end
            FUNC_RD_TERM:
            begin
                if (it.tidx < DEF_MAX_TERMS)
                    r.data = term_tbl[it.tidx];
                else
                begin
                    r.data = '0;
                    r.st   = ST_RANGE;
                end
            end
            FUNC_RD_OUT:
            begin
                if (it.bout < DEF_MAX_OUTPUTS)
                    r.data = out_tbl[it.bout];
                else
                begin
                    r.data = '0;
                    r.st   = ST_RANGE;
                end
            end
            default:
            begin
                clear_stores();
                r.data = '0;
            end
        endcase
        r.ones = ones_sum;
        return r;
    endfunction

    function automatic logic [255:0] rand256();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Term values biased towards the interesting corners of a given width
    function automatic logic [255:0] pick_term(input int nb);
        int unsigned top;
        top = (nb > 32) ? 255 : 8 * nb - 1;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return (nb == 0) ? rand256() : (256'd1 << top);
            3: return (nb == 0) ? rand256() : (rand256() | (256'd1 << top));
            default: return rand256();
        endcase
    endfunction

    function automatic agg_item_t build_item(input func_t op, input logic [255:0] term,
                                             input int nbytes, input bit sgn,
                                             input int tidx, input int bout);
        agg_item_t it;
        it.op     = op;
        it.term   = term;
        it.nbytes = 6'(nbytes);
        it.sgn    = sgn;
        it.tidx   = 10'(tidx);
        it.bout   = 6'(bout);
        return it;
    endfunction

    // Drives one beat, waits for it to be taken, then idles for a random spell unless back_to_back is set
    task automatic issue_item(input agg_item_t it);
        int gap;
        func        <= it.op;
        term_w0     <= it.term[63:0];
        term_w1     <= it.term[127:64];
        term_w2     <= it.term[191:128];
        term_w3     <= it.term[255:192];
        term_bytes  <= it.nbytes;
        term_sgn    <= it.sgn;
        term_pos    <= it.tidx;
        base_output <= it.bout;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        agg_results_due.push_back(compute_agg_result(it));
        gap = back_to_back ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender off until every outstanding answer has come back
    task automatic wait_for_results();
        start <= 1'b0;
        while (agg_results_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    // Result checker: every done beat against the oldest prediction
    always @(posedge clk)
    begin : result_check
        agg_result_t want;
        if (rst_n && done)
        begin
            if (agg_results_due.size() == 0)
            begin
                $error("done beat with no result outstanding");
                err_count++;
            end
            else
            begin
                want = agg_results_due.pop_front();
                check_field("data_w0", want.data[63:0], data_w0);
                check_field("data_w1", want.data[127:64], data_w1);
                check_field("data_w2", want.data[191:128], data_w2);
                check_field("data_w3", want.data[255:192], data_w3);
                check_field("total_ones", 64'(want.ones), 64'(total_ones));
                check_field("went_negative", 64'(want.neg), 64'(went_negative));
                check_field("status", 64'(want.st), 64'(status));
            end
        end
    end

    // Field extremes, zero and over-wide unsigned terms, and every read
    task automatic test_extremes();
        issue_item(build_item(FUNC_AGG, '1, 32, 1'b0, 1023, 63));
        issue_item(build_item(FUNC_AGG, rand256(), 0, 1'b0, 0, 0));
        issue_item(build_item(FUNC_AGG, rand256(), 63, 1'b0, 512, 31));
        issue_item(build_item(FUNC_AGG, '1, 1, 1'b0, 1, 1));
        issue_item(build_item(FUNC_RD_TERM, '0, 0, 1'b0, 1023, 0));
        issue_item(build_item(FUNC_RD_TERM, '1, 63, 1'b1, 0, 63));
        issue_item(build_item(FUNC_RD_OUT, '0, 0, 1'b0, 0, 63));
        issue_item(build_item(FUNC_RD_OUT, '1, 63, 1'b1, 1023, 0));
    endtask

    // Negative, most negative, bad signed width and the top output slot
    task automatic test_signed();
        int w;
        for (int k = 0; k < 5; k++)
        begin
            w = 1 << k;
            issue_item(build_item(FUNC_AGG, '1, w, 1'b1, k, 2 * k));
            issue_item(build_item(FUNC_AGG, 256'd1 << (8 * w - 1), w, 1'b1, k + 8, 2 * k));
        end
        issue_item(build_item(FUNC_AGG, 256'h7fff, SIGNED_MAX_BYTES, 1'b1, 20, 40));
        issue_item(build_item(FUNC_AGG, '1, 3, 1'b1, 21, 41));
        issue_item(build_item(FUNC_AGG, '1, 0, 1'b1, 22, 42));
        issue_item(build_item(FUNC_AGG, '1, 63, 1'b1, 23, 43));
        // negative term on the last slot has nowhere to go
        issue_item(build_item(FUNC_AGG, 256'hff, 1, 1'b1, 24, 63));
        issue_item(build_item(FUNC_AGG, 256'h80, 1, 1'b1, 25, 63));
    endtask

    // Clear empties every store; reads and aggregation start afresh
    task automatic test_clear();
        issue_item(build_item(FUNC_CLEAR, rand256(), 5, 1'b1, 7, 7));
        issue_item(build_item(FUNC_RD_TERM, '0, 0, 1'b0, 1023, 0));
        issue_item(build_item(FUNC_RD_OUT, '0, 0, 1'b0, 0, 63));
        issue_item(build_item(FUNC_AGG, 256'h1234, 2, 1'b0, 3, 5));
    endtask

    task automatic test_random(input int count);
        agg_item_t it;
        int        pick;
        int        nb;
        for (int n = 0; n < count; n++)
        begin
            // now and then a run of back-to-back beats
            if (n % 50 == 0)
                back_to_back = ($urandom_range(0, 2) == 0);
            pick      = $urandom_range(0, 99);
            it.sgn    = 1'($urandom_range(0, 1));
            it.term   = rand256();
            it.nbytes = 6'($urandom_range(0, 63));
            if (pick < 70)
            begin
                it.op = FUNC_AGG;
                if (it.sgn && $urandom_range(0, 9) != 0)
                    nb = 1 << $urandom_range(0, 4);
                else if ($urandom_range(0, 9) == 0)
                    nb = $urandom_range(0, 63);
                else
                    nb = $urandom_range(1, 32);
                it.nbytes = 6'(nb);
                it.term   = pick_term(nb);
            end
            else if (pick < 85)
                it.op = FUNC_RD_TERM;
            else if (pick < 98)
                it.op = FUNC_RD_OUT;
            else
                it.op = FUNC_CLEAR;
            // a few hot slots so that entries build up and reads see them
            it.tidx = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                                  : 10'($urandom_range(0, 15));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                it.bout = 6'($urandom_range(0, 63));
            else if (pick == 1)
                it.bout = 6'($urandom_range(62, 63));
            else
                it.bout = 6'($urandom_range(0, 7));
            issue_item(it);
        end
        back_to_back = 1'b0;
    endtask

    task automatic test_sender_pause();
        test_random(400);
        wait_for_results();
        test_random(400);
    endtask

    // Sequence
    initial
    begin
        err_count    = 0;
        back_to_back = 1'b0;
        clear_stores();
        rst_n       <= 1'b0;
        start       <= 1'b0;
        func        <= FUNC_AGG;
        term_w0     <= '0;
        term_w1     <= '0;
        term_w2     <= '0;
        term_w3     <= '0;
        term_bytes  <= '0;
        term_sgn    <= 1'b0;
        term_pos    <= '0;
        base_output <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_signed();
        test_clear();
        test_sender_pause();

        wait_for_results();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
